// ===== sv/priority_task_queue_top_defines.svh =====
// assertion macros for the priority task queue
`ifndef PRIORITY_TASK_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_TASK_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge outside reset
`define PTQ_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PTQ_ASSERT_SAME(lbl, ante, cons, msg)
`define PTQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/ptq_pkg.sv =====
// shared types, codes and the entry ordering function of the priority task queue
package ptq_pkg;

   localparam int DEPTH_DEFAULT = 128;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_INSERTED  = 2'd0,
      ST_REMOVED   = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [4:0]  hh;
      logic [5:0]  mm;
      logic [5:0]  ss;
      logic [15:0] pri;
   } entry_type;

   typedef struct packed {
      op_type      op;
      entry_type   entry;
   } req_type;

   typedef struct packed {
      status_type  status;
      entry_type   entry;
      logic [7:0]  occupancy;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic dispatch;
      logic scan_step;
      logic shift_start;
      logic shift_step;
      logic remove_done;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_insert;
      logic empty;
      logic scan_last;
      logic shift_none;
      logic shift_last;
      logic rsp_free;
   } stat_type;

   // true when c ranks ahead of b: larger priority, then earlier arrival
   function automatic logic better(entry_type c, entry_type b);
      logic earlier;
      earlier = (c.hh != b.hh) ? (c.hh < b.hh) :
                (c.mm != b.mm) ? (c.mm < b.mm) : (c.ss < b.ss);
      return (c.pri > b.pri) || ((c.pri == b.pri) && earlier);
   endfunction

endpackage

// ===== sv/ptq_req_if.sv =====
// request channel interface of the priority task queue
interface ptq_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] user_id;
   logic [4:0]  arrive_hour;
   logic [5:0]  arrive_minute;
   logic [5:0]  arrive_second;
   logic [15:0] priority_req;

   modport source (
      output valid, op, user_id, arrive_hour, arrive_minute, arrive_second, priority_req,
      input  ready
   );
   modport sink (
      input  valid, op, user_id, arrive_hour, arrive_minute, arrive_second, priority_req,
      output ready
   );
endinterface

// ===== sv/ptq_rsp_if.sv =====
// response channel interface of the priority task queue
interface ptq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_user;
   logic [4:0]  out_hour;
   logic [5:0]  out_minute;
   logic [5:0]  out_second;
   logic [15:0] out_priority;
   logic [7:0]  occupancy;

   modport source (
      output valid, status, out_user, out_hour, out_minute, out_second, out_priority,
             occupancy,
      input  ready
   );
   modport sink (
      input  valid, status, out_user, out_hour, out_minute, out_second, out_priority,
             occupancy,
      output ready
   );
endinterface

// ===== sv/ptq_ram.sv =====
// generic simple dual-port ram with registered read
module ptq_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ptq_ctrl.sv =====
// controller state machine of the priority task queue
module ptq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptq_pkg::stat_type stat,
   output ptq_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE        = 6'b000001,
      S_DISPATCH    = 6'b000010,
      S_SCAN        = 6'b000100,
      S_SHIFT_START = 6'b001000,
      S_SHIFT       = 6'b010000,
      S_DONE        = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            cmd.dispatch = 1'b1;
            if (stat.is_insert || stat.empty) state_in = S_DONE;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) state_in = S_SHIFT_START;
         end
         S_SHIFT_START: begin
            cmd.shift_start = 1'b1;
            if (stat.shift_none) begin
               cmd.remove_done = 1'b1;
               state_in        = S_DONE;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (stat.shift_last) begin
               cmd.remove_done = 1'b1;
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            cmd.load_rsp = stat.rsp_free;
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/ptq_datapath.sv =====
// datapath of the priority task queue: entry ram, count, scan and shift indexes, response register
module ptq_datapath #(
   parameter int DEPTH = ptq_pkg::DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ptq_pkg::cmd_type  cmd,
   output ptq_pkg::stat_type stat,
   input  ptq_pkg::req_type  req_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output ptq_pkg::rsp_type  rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = CW + 1;

   ptq_pkg::req_type    req_ff;
   logic [CW-1:0]       count_ff;
   logic [IW-1:0]       cmp_idx_ff;
   logic [IW-1:0]       best_idx_ff;
   logic [IW-1:0]       shift_idx_ff;
   ptq_pkg::entry_type  best_entry_ff;
   ptq_pkg::status_type res_status_ff;
   logic                rsp_valid_ff;
   ptq_pkg::rsp_type    rsp_ff;

   logic                full;
   logic [AW-1:0]       rd_wide;
   logic [IW-1:0]       rd_addr;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   ptq_pkg::entry_type  wr_data;
   ptq_pkg::entry_type  rd_data;

   assign full = (count_ff == CW'(DEPTH));

   always_comb begin
      if (cmd.dispatch) rd_wide = '0;
      else if (cmd.scan_step) rd_wide = AW'(cmp_idx_ff) + AW'(1);
      else if (cmd.shift_start) rd_wide = AW'(best_idx_ff) + AW'(1);
      else rd_wide = AW'(shift_idx_ff) + AW'(2);
      // reads past the last entry are never used, keep the address in range
      rd_addr = (rd_wide < AW'(DEPTH)) ? IW'(rd_wide) : '0;
   end

   assign wr_en   = (cmd.dispatch && (req_ff.op == ptq_pkg::OP_INSERT) && !full)
                    || cmd.shift_step;
   assign wr_addr = cmd.shift_step ? shift_idx_ff : IW'(count_ff);
   assign wr_data = cmd.shift_step ? rd_data : req_ff.entry;

   ptq_ram #(
      .WIDTH ($bits(ptq_pkg::entry_type)),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.is_insert  = (req_ff.op == ptq_pkg::OP_INSERT);
   assign stat.empty      = (count_ff == '0);
   assign stat.scan_last  = ((AW'(cmp_idx_ff) + AW'(1)) == AW'(count_ff));
   assign stat.shift_none = ((AW'(best_idx_ff) + AW'(1)) == AW'(count_ff));
   assign stat.shift_last = ((AW'(shift_idx_ff) + AW'(2)) == AW'(count_ff));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.dispatch && (req_ff.op == ptq_pkg::OP_INSERT) && !full) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.remove_done) begin
            count_ff <= count_ff - CW'(1);
         end
         if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload and index registers
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      if (cmd.dispatch) begin
         cmp_idx_ff <= '0;
         if (req_ff.op == ptq_pkg::OP_INSERT) begin
            res_status_ff <= full ? ptq_pkg::ST_OVERFLOW : ptq_pkg::ST_INSERTED;
         end else if (count_ff == '0) begin
            res_status_ff <= ptq_pkg::ST_UNDERFLOW;
         end
      end
      if (cmd.scan_step) begin
         if ((cmp_idx_ff == '0) || ptq_pkg::better(rd_data, best_entry_ff)) begin
            best_entry_ff <= rd_data;
            best_idx_ff   <= cmp_idx_ff;
         end
         cmp_idx_ff <= cmp_idx_ff + IW'(1);
      end
      if (cmd.shift_start) shift_idx_ff <= best_idx_ff;
      if (cmd.shift_step) shift_idx_ff <= shift_idx_ff + IW'(1);
      if (cmd.remove_done) res_status_ff <= ptq_pkg::ST_REMOVED;
      if (cmd.load_rsp) begin
         rsp_ff.status    <= res_status_ff;
         rsp_ff.entry     <= (res_status_ff == ptq_pkg::ST_REMOVED) ? best_entry_ff : '0;
         rsp_ff.occupancy <= 8'(count_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/priority_task_queue_top.sv =====
// top level of the priority task queue: controller, datapath and channel hookup
//
// - req_ch carries one operation per transfer: insert (user tag, arrival time and
//   priority) or remove of the best entry; rsp_ch returns exactly one result per request
// - remove picks the largest priority, then the earliest arrival (hour, minute,
//   second as raw bits), then the oldest insertion; later entries close the gap
// - insert, overflow and underflow pass through dispatch straight to the response load;
//   a remove on n entries adds a scan pass over all n and a shift pass over the
//   n - 1 - pos entries after the chosen one, pos being the place of the chosen entry
// - one request at a time; the next request transfer can follow in the cycle after
//   the response is loaded
// - a remove is bound by the single read port of the entry ram: one pass compares
//   every entry, a second pass copies each later entry one place down
// - req_ch.ready is high while the block idles, also while a response waits to leave
// - a stalled rsp_ch holds its response; a second finished result waits inside
//   until the output register frees up, and no further request is taken meanwhile
// - reset empties the queue at once; the entry ram holds no reset value and only
//   entries written since are ever read
// - status: inserted, removed, underflow on an empty queue, overflow on a full one;
//   the entry fields are zero unless an entry was removed
`include "priority_task_queue_top_defines.svh"

module priority_task_queue_top #(
   parameter int DEPTH = ptq_pkg::DEPTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   ptq_req_if.sink  req_ch,
   ptq_rsp_if.source rsp_ch
);

   ptq_pkg::cmd_type  cmd;
   ptq_pkg::stat_type stat;
   ptq_pkg::req_type  req_data;
   ptq_pkg::rsp_type  rsp_data;
   logic              rsp_valid;
   logic              req_transfer;
   logic              rsp_no_entry;
   logic              rsp_fields_zero;
   logic              rsp_underflow;

   // request payload gathered into one word for the datapath capture register
   assign req_data.op        = ptq_pkg::op_type'(req_ch.op);
   assign req_data.entry.tag = req_ch.user_id;
   assign req_data.entry.hh  = req_ch.arrive_hour;
   assign req_data.entry.mm  = req_ch.arrive_minute;
   assign req_data.entry.ss  = req_ch.arrive_second;
   assign req_data.entry.pri = req_ch.priority_req;

   // sequencing of dispatch, scan pass, shift pass and response load
   ptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry ram, occupancy count, best-entry tracking and output register
   ptq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // response channel straight from the output register
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.status       = rsp_data.status;
   assign rsp_ch.out_user     = rsp_data.entry.tag;
   assign rsp_ch.out_hour     = rsp_data.entry.hh;
   assign rsp_ch.out_minute   = rsp_data.entry.mm;
   assign rsp_ch.out_second   = rsp_data.entry.ss;
   assign rsp_ch.out_priority = rsp_data.entry.pri;
   assign rsp_ch.occupancy    = rsp_data.occupancy;

   // conditions watched by the checks below
   assign req_transfer    = req_ch.valid && req_ch.ready;
   assign rsp_no_entry    = rsp_ch.valid && (rsp_ch.status != ptq_pkg::ST_REMOVED);
   assign rsp_fields_zero = (rsp_ch.out_user == '0) && (rsp_ch.out_priority == '0)
                            && (rsp_ch.out_hour == '0) && (rsp_ch.out_minute == '0)
                            && (rsp_ch.out_second == '0);
   assign rsp_underflow   = rsp_ch.valid && (rsp_ch.status == ptq_pkg::ST_UNDERFLOW);

   // a request transfer starts work, so the next cycle is busy
   `PTQ_ASSERT_NEXT(a_busy_after_transfer, req_transfer, !req_ch.ready, "taken while busy")

   // entry fields are cleared unless an entry comes out
   `PTQ_ASSERT_SAME(a_zero_fields, rsp_no_entry, rsp_fields_zero, "entry fields not cleared")

   // underflow only on an empty queue
   `PTQ_ASSERT_SAME(a_underflow_empty, rsp_underflow, rsp_ch.occupancy == '0, "underflow held")

endmodule
